// ----- design/sha1_pkg.sv -----
package sha1_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  typedef enum logic [2:0] {
    WSRC_DATA,
    WSRC_PAD,
    WSRC_ZERO,
    WSRC_LEN
  } wsrc_t;

  typedef struct packed {
    logic  wr_en;
    wsrc_t wr_src;
    logic  len_inc;
    logic  round_start;
    logic  round_step;
    logic  chain_update;
    logic  chain_init;
    logic  latch_len;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
  } dp_status_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

// ----- design/sha1_datapath.sv -----
module sha1_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  sha1_pkg::dp_cmd_t   cmd,
  input  logic [5:0]          pad_idx,
  input  logic [2:0]          out_sel,
  output sha1_pkg::dp_status_t status,
  output logic [31:0]         digest_word
);
  import sha1_pkg::*;

  logic [31:0] h [5];
  logic [63:0] bit_length;
  logic [63:0] len_hold;
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  round;
  logic [5:0]  wr_idx;
  logic [7:0]  wr_data;
  logic [31:0] f, k, wt, wnew, tmp;

  assign wr_idx = (cmd.wr_src == WSRC_DATA) ? bit_length[8:3] : pad_idx;

  always_comb begin
    unique case (cmd.wr_src)
      WSRC_DATA: wr_data = data_byte;
      WSRC_PAD:  wr_data = PAD_BYTE;
      WSRC_LEN:  wr_data = len_hold[63 - 8*pad_idx[2:0] -: 8];
      default:   wr_data = 8'h00;
    endcase
  end

  assign wnew = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
  assign wt = (round < 7'd16) ? w[0] : wnew;

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign tmp = rotl(a, 5) + f + e + k + wt;

  // The block bytes are collected big-endian straight into the schedule words.
  always_ff @(posedge clk) begin
    if (cmd.round_start) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= wt;
      e <= d;
      d <= c;
      c <= rotl(b, 30);
      b <= a;
      a <= tmp;
    end else if (cmd.wr_en) begin
      w[wr_idx[5:2]][{~wr_idx[1:0], 3'b000} +: 8] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.round_start) begin
      round <= '0;
    end else if (cmd.round_step) begin
      round <= round + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_len) begin
      len_hold <= bit_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.chain_init) begin
      h[0] <= H0_INIT;
      h[1] <= H1_INIT;
      h[2] <= H2_INIT;
      h[3] <= H3_INIT;
      h[4] <= H4_INIT;
      bit_length <= '0;
    end else begin
      if (cmd.chain_update) begin
        h[0] <= h[0] + a;
        h[1] <= h[1] + b;
        h[2] <= h[2] + c;
        h[3] <= h[3] + d;
        h[4] <= h[4] + e;
      end
      if (cmd.len_inc) begin
        bit_length <= bit_length + 64'd8;
      end
    end
  end

  always_comb begin
    unique case (out_sel)
      3'd0:    digest_word = h[0];
      3'd1:    digest_word = h[1];
      3'd2:    digest_word = h[2];
      3'd3:    digest_word = h[3];
      default: digest_word = h[4];
    endcase
  end

  assign status.fill = bit_length[8:3];
  assign status.round_last = (round == 7'd79);

endmodule

// ----- design/sha1_ctrl.sv -----
module sha1_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 byte_present,
  input  logic                 end_of_message,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sha1_pkg::dp_status_t status,
  output sha1_pkg::dp_cmd_t    cmd,
  output logic [5:0]           pad_idx,
  output logic [2:0]           out_sel
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MARK  = 3'd1;
  localparam logic [2:0] S_PAD   = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state, state_next;
  logic [5:0] idx, idx_next;
  logic       fin, fin_next;
  logic       len_done, len_done_next;
  logic       mark_done, mark_done_next;
  logic [2:0] osel, osel_next;
  logic       acc;

  assign in_ready = (state == S_IDLE);
  assign acc = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  assign pad_idx = (state == S_MARK) ? status.fill : idx;
  assign out_sel = osel;

  always_comb begin
    state_next = state;
    idx_next = idx;
    fin_next = fin;
    len_done_next = len_done;
    osel_next = osel;
    cmd = '0;
    cmd.wr_src = WSRC_DATA;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          fin_next = end_of_message;
          len_done_next = 1'b0;
          if (byte_present) begin
            cmd.wr_en = 1'b1;
            cmd.len_inc = 1'b1;
          end
          if (byte_present && status.fill == 6'd63) begin
            state_next = S_LOAD;
          end else if (end_of_message) begin
            state_next = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmd.wr_en = 1'b1;
        cmd.wr_src = WSRC_PAD;
        cmd.latch_len = 1'b1;
        idx_next = status.fill + 6'd1;
        len_done_next = 1'b0;
        if (status.fill == 6'd63) begin
          state_next = S_LOAD;
        end else begin
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        cmd.wr_en = 1'b1;
        if (idx >= LEN_POS && len_done) begin
          cmd.wr_src = WSRC_LEN;
        end else begin
          cmd.wr_src = WSRC_ZERO;
        end
        idx_next = idx + 6'd1;
        if (idx == 6'd63) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.round_start = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_step = 1'b1;
        if (status.round_last) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.chain_update = 1'b1;
        if (!fin) begin
          state_next = S_IDLE;
        end else if (len_done) begin
          osel_next = 3'd0;
          state_next = S_OUT;
        end else if (!mark_done) begin
          state_next = S_MARK;
        end else begin
          len_done_next = 1'b1;
          idx_next = 6'd0;
          state_next = S_PAD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          osel_next = osel + 3'd1;
          if (osel == 3'd4) begin
            cmd.chain_init = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mark_done_next = mark_done;
    if (state == S_IDLE) begin
      mark_done_next = 1'b0;
    end else if (state == S_MARK) begin
      mark_done_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fin <= 1'b0;
      len_done <= 1'b0;
      mark_done <= 1'b0;
      osel <= '0;
      idx <= '0;
    end else begin
      state <= state_next;
      fin <= fin_next;
      mark_done <= mark_done_next;
      osel <= osel_next;
      idx <= (state == S_MARK) ? status.fill + 6'd1 : idx_next;
      if (state == S_MARK) begin
        len_done <= (status.fill < 6'd56);
      end else begin
        len_done <= len_done_next;
      end
    end
  end

endmodule

// ----- design/sha1_byte_stream_hasher.sv -----
// SHA-1 hasher that takes a message one byte per transfer on the s_axis
// channel and returns the digest on the m_axis channel.
// Each input transfer carries a byte (with tuser bit 0 set when it is
// valid) and tlast on the final transfer of a message; tlast may come
// with or without a byte, so an empty message is allowed.
// A byte that does not complete a 64-byte block is written straight in;
// the 64th byte starts a compression, one round per cycle in a single
// shared round unit, during which s_axis_tready is low.
// On tlast the block is padded one byte per cycle, compressed once or
// twice, and the five digest words h0..h4 are sent as five transfers,
// with m_axis_tlast on h4.
// A stall on m_axis holds the current word; no input is taken until all
// five words have gone. After the last word the chaining values return
// to the initial values for the next message.
// Reset returns the block to the initial values with no message pending.
module sha1_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], word_index[34:32], zero fill
  output logic        m_axis_tlast    // last_word
);
  import sha1_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [5:0] pad_idx;
  logic [2:0] out_sel;
  logic [31:0] digest_word;

  sha1_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .byte_present(s_axis_tuser), .end_of_message(s_axis_tlast),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .status(status), .cmd(cmd), .pad_idx(pad_idx), .out_sel(out_sel)
  );

  sha1_datapath u_dp (
    .clk(clk), .rst(rst), .data_byte(s_axis_tdata), .cmd(cmd),
    .pad_idx(pad_idx), .out_sel(out_sel), .status(status),
    .digest_word(digest_word)
  );

  assign m_axis_tdata = {5'd0, out_sel, digest_word};
  assign m_axis_tlast = (out_sel == 3'd4);

endmodule
